@@ hdl/swsc_pkg.sv @@
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared types and constants of the go-back-n sender congestion control.
// ----------------------------------------------------------------------------
package swsc_pkg;

    // fixed field widths
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned WIN_W      = 7;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // threshold loaded at reset
    localparam logic [WIN_W-1:0] START_THRESHOLD_RST = 7'd16;

    // register map (word index)
    localparam logic REG_START_THRESHOLD = 1'b0;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input command codes
    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SEND_NEW     = 3'd0,
        KIND_RESEND       = 3'd1,
        KIND_ACK_DONE     = 3'd2,
        KIND_TIMEOUT_DONE = 3'd3,
        KIND_WAIT         = 3'd4,
        KIND_EXHAUSTED    = 3'd5
    } t_kind;

    // decoded operation
    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TIMEOUT,
        OP_NONE
    } t_op;

    // back end state
    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } t_back_state;

    // input item
    typedef struct packed {
        logic [1:0]        cmd;
        logic              have_new;
        logic [DATA_W-1:0] ack_number;
    } t_in_item;

    // result item
    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] seq_number;
        logic [DATA_W-1:0] window_base;
        logic [WIN_W-1:0]  window_size;
        logic [WIN_W-1:0]  threshold;
        logic              last;
    } t_out_item;

    // queued command
    typedef struct packed {
        t_op               op;
        logic              have_new;
        logic [DATA_W-1:0] ack_number;
    } t_op_entry;

    // front to queue
    typedef struct packed {
        logic      valid;
        t_op_entry entry;
    } t_q_push;

    // queue to back
    typedef struct packed {
        logic      valid;
        t_op_entry entry;
    } t_q_head;

    // threshold register write towards the back end
    typedef struct packed {
        logic             wr;
        logic [WIN_W-1:0] value;
    } t_cfg_wr;

endpackage

@@ hdl/swsc_stream_if.sv @@
// ----------------------------------------------------------------------------
// swsc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface swsc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/swsc_cfg.sv @@
// ----------------------------------------------------------------------------
// swsc_cfg
// APB register block holding the start threshold.
// ----------------------------------------------------------------------------
module swsc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output swsc_pkg::t_cfg_wr                   o_cfg_wr
);

    logic [swsc_pkg::WIN_W-1:0] r_start_threshold;
    logic [swsc_pkg::WIN_W-1:0] n_start_threshold;
    logic                       sel_thr;
    logic                       wr_en;

    // address decode
    assign sel_thr = (paddr[2] == swsc_pkg::REG_START_THRESHOLD);
    assign wr_en   = psel && penable && pwrite && sel_thr;
    assign pready  = 1'b1;

    // register update
    always_comb begin
        n_start_threshold = r_start_threshold;
        if (wr_en) begin
            n_start_threshold = pwdata[swsc_pkg::WIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_threshold <= swsc_pkg::START_THRESHOLD_RST;
        end else begin
            r_start_threshold <= n_start_threshold;
        end
    end

    // read back
    assign prdata = sel_thr
        ? {{(swsc_pkg::APB_DATA_W - swsc_pkg::WIN_W){1'b0}}, r_start_threshold}
        : '0;

    // write strobe to the back end, which reloads its threshold
    assign o_cfg_wr.wr    = wr_en;
    assign o_cfg_wr.value = pwdata[swsc_pkg::WIN_W-1:0];

endmodule

@@ hdl/swsc_front.sv @@
// ----------------------------------------------------------------------------
// swsc_front
// Accepts input items and decodes them into queued operations.
// ----------------------------------------------------------------------------
module swsc_front (
    swsc_stream_if.sink          i_item,
    input  logic                 i_full,
    output swsc_pkg::t_q_push    o_push
);

    swsc_pkg::t_op op;

    // command decode
    always_comb begin
        unique case (i_item.data.cmd)
            swsc_pkg::CMD_SEND:    op = swsc_pkg::OP_SEND;
            swsc_pkg::CMD_ACK:     op = swsc_pkg::OP_ACK;
            swsc_pkg::CMD_TIMEOUT: op = swsc_pkg::OP_TIMEOUT;
            default:               op = swsc_pkg::OP_NONE;
        endcase
    end

    // push on every transfer
    assign i_item.ready            = !i_full;
    assign o_push.valid            = i_item.valid && !i_full;
    assign o_push.entry.op         = op;
    assign o_push.entry.have_new   = i_item.data.have_new;
    assign o_push.entry.ack_number = i_item.data.ack_number;

endmodule

@@ hdl/swsc_queue.sv @@
// ----------------------------------------------------------------------------
// swsc_queue
// Short fifo of decoded operations between front and back end.
// ----------------------------------------------------------------------------
module swsc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swsc_pkg::t_q_push    i_push,
    input  logic                 i_pop,
    output logic                 o_full,
    output swsc_pkg::t_q_head    o_head
);

    swsc_pkg::t_op_entry              r_mem [swsc_pkg::QUEUE_DEPTH];
    logic [swsc_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [swsc_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [swsc_pkg::QCNT_W-1:0]      r_count;
    logic [swsc_pkg::QPTR_W-1:0]      n_wr_ptr;
    logic [swsc_pkg::QPTR_W-1:0]      n_rd_ptr;
    logic [swsc_pkg::QCNT_W-1:0]      n_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full       = (r_count == swsc_pkg::QCNT_W'(swsc_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

@@ hdl/swsc_back.sv @@
// ----------------------------------------------------------------------------
// swsc_back
// Executes queued operations on the window state and drives the results.
// ----------------------------------------------------------------------------
module swsc_back #(
    parameter int unsigned MAX_WINDOW = 64,
    parameter int unsigned SEQ_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swsc_pkg::t_q_head    i_head,
    output logic                 o_pop,
    input  swsc_pkg::t_cfg_wr    i_cfg_wr,
    swsc_stream_if.source        o_result
);

    localparam int unsigned WIN_W = swsc_pkg::WIN_W;
    localparam logic [WIN_W-1:0] MAX_WIN = WIN_W'(MAX_WINDOW);

    // window state
    logic [WIN_W-1:0]       r_cwnd,     n_cwnd;
    logic [WIN_W-1:0]       r_ssthresh, n_ssthresh;
    logic [SEQ_BITS-1:0]    r_base,     n_base;
    logic [SEQ_BITS-1:0]    r_tx,       n_tx;
    logic [SEQ_BITS-1:0]    r_new,      n_new;
    logic [SEQ_BITS-1:0]    r_acked,    n_acked;
    swsc_pkg::t_back_state  r_state,    n_state;

    // output register
    logic                   r_out_valid, n_out_valid;
    swsc_pkg::t_out_item    r_out,       n_out;
    logic                   load;

    // shared datapath terms
    logic [SEQ_BITS:0]      wend;
    logic [SEQ_BITS-1:0]    tx_inc;
    logic                   resend_ok;
    logic                   more;
    logic                   can_emit;
    logic [SEQ_BITS-1:0]    ack_a;
    logic [SEQ_BITS-1:0]    ack_a1;
    logic [WIN_W:0]         grown;
    logic [WIN_W-1:0]       grown_sat;
    logic [WIN_W-1:0]       half_cwnd;

    function automatic logic [WIN_W-1:0] clamp_thr(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        if (v == '0) begin
            r = WIN_W'(1);
        end else if (v > MAX_WIN) begin
            r = MAX_WIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic swsc_pkg::t_out_item make_item(
        input swsc_pkg::t_kind     kind,
        input logic [SEQ_BITS-1:0] seq,
        input logic [SEQ_BITS-1:0] base,
        input logic [WIN_W-1:0]    cwnd,
        input logic [WIN_W-1:0]    thr,
        input logic                last
    );
        swsc_pkg::t_out_item it;
        logic [31:0]         seq32;
        logic [31:0]         base32;
        seq32          = 32'(seq);
        base32         = 32'(base);
        it.kind        = kind;
        it.seq_number  = seq32[swsc_pkg::DATA_W-1:0];
        it.window_base = base32[swsc_pkg::DATA_W-1:0];
        it.window_size = cwnd;
        it.threshold   = thr;
        it.last        = last;
        return it;
    endfunction

    // window end and resend conditions
    assign wend      = {1'b0, r_base} + (SEQ_BITS+1)'(r_cwnd);
    assign tx_inc    = r_tx + 1'b1;
    assign resend_ok = ({1'b0, r_tx} < wend) && (r_tx < r_new);
    assign more      = ({1'b0, tx_inc} < wend) && (tx_inc < r_new);
    assign can_emit  = !r_out_valid || o_result.ready;

    // ack number in sequence space
    assign ack_a  = SEQ_BITS'(32'(i_head.entry.ack_number));
    assign ack_a1 = ack_a + 1'b1;

    // window growth: double in slow start, else plus one, saturating
    assign grown     = (r_cwnd < r_ssthresh) ? {r_cwnd, 1'b0} : ({1'b0, r_cwnd} + 1'b1);
    assign grown_sat = (grown > {1'b0, MAX_WIN}) ? MAX_WIN : grown[WIN_W-1:0];
    assign half_cwnd = r_cwnd >> 1;

    // next state and result
    always_comb begin
        n_cwnd     = r_cwnd;
        n_ssthresh = r_ssthresh;
        n_base     = r_base;
        n_tx       = r_tx;
        n_new      = r_new;
        n_acked    = r_acked;
        n_state    = r_state;
        n_out      = r_out;
        load       = 1'b0;
        o_pop      = 1'b0;

        unique case (r_state)
            swsc_pkg::BK_IDLE: begin
                if (i_head.valid && can_emit) begin
                    o_pop = 1'b1;
                    load  = 1'b1;
                    case (i_head.entry.op)
                        swsc_pkg::OP_SEND: begin
                            if (resend_ok) begin
                                // first number of a resend burst
                                n_out = make_item(swsc_pkg::KIND_RESEND, r_tx, r_base,
                                                  r_cwnd, r_ssthresh, !more);
                                n_tx  = tx_inc;
                                if (more) begin
                                    n_state = swsc_pkg::BK_BURST;
                                end
                            end else if (({1'b0, r_new} < wend) && i_head.entry.have_new) begin
                                if (&r_new) begin
                                    n_out = make_item(swsc_pkg::KIND_EXHAUSTED, '0, r_base,
                                                      r_cwnd, r_ssthresh, 1'b1);
                                end else begin
                                    n_out = make_item(swsc_pkg::KIND_SEND_NEW, r_new, r_base,
                                                      r_cwnd, r_ssthresh, 1'b1);
                                    n_new = r_new + 1'b1;
                                    n_tx  = r_new + 1'b1;
                                end
                            end else begin
                                n_out = make_item(swsc_pkg::KIND_WAIT, '0, r_base,
                                                  r_cwnd, r_ssthresh, 1'b1);
                            end
                        end
                        swsc_pkg::OP_ACK: begin
                            // acks of unsent numbers are ignored
                            if (ack_a < r_new) begin
                                if (ack_a1 > r_acked) begin
                                    n_acked = ack_a1;
                                end
                                // whole window covered: slide and grow
                                if ({1'b0, ack_a1} >= wend) begin
                                    n_base = ack_a1;
                                    n_cwnd = grown_sat;
                                    if (r_tx < ack_a1) begin
                                        n_tx = ack_a1;
                                    end
                                end
                            end
                            n_out = make_item(swsc_pkg::KIND_ACK_DONE, '0, n_base,
                                              n_cwnd, r_ssthresh, 1'b1);
                        end
                        swsc_pkg::OP_TIMEOUT: begin
                            n_ssthresh = (half_cwnd == '0) ? WIN_W'(1) : half_cwnd;
                            n_cwnd     = WIN_W'(1);
                            n_tx       = r_acked;
                            if (r_acked > r_base) begin
                                n_base = r_acked;
                            end
                            n_out = make_item(swsc_pkg::KIND_TIMEOUT_DONE, '0, n_base,
                                              n_cwnd, n_ssthresh, 1'b1);
                        end
                        default: begin
                            n_out = make_item(swsc_pkg::KIND_WAIT, '0, r_base,
                                              r_cwnd, r_ssthresh, 1'b1);
                        end
                    endcase
                end
            end
            swsc_pkg::BK_BURST: begin
                // one resend per cycle while the output accepts, up to window end or newest number
                if (can_emit) begin
                    load  = 1'b1;
                    n_out = make_item(swsc_pkg::KIND_RESEND, r_tx, r_base,
                                      r_cwnd, r_ssthresh, !more);
                    n_tx  = tx_inc;
                    if (!more) begin
                        n_state = swsc_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = swsc_pkg::BK_IDLE;
            end
        endcase

        // threshold register write reloads the threshold
        if (i_cfg_wr.wr) begin
            n_ssthresh = clamp_thr(i_cfg_wr.value);
        end
    end

    // output register handshake
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd      <= WIN_W'(1);
            r_ssthresh  <= clamp_thr(swsc_pkg::START_THRESHOLD_RST);
            r_base      <= '0;
            r_tx        <= '0;
            r_new       <= '0;
            r_acked     <= '0;
            r_state     <= swsc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_cwnd      <= n_cwnd;
            r_ssthresh  <= n_ssthresh;
            r_base      <= n_base;
            r_tx        <= n_tx;
            r_new       <= n_new;
            r_acked     <= n_acked;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

@@ hdl/sliding_window_sender_congestion_ctl.sv @@
// Path: an input item is written into the command queue, then popped into the
//   back end's output register, where its result waits while the output stalls.
// Throughput: while the output accepts, one input item per cycle for single-result
//   commands, and one result per cycle of a resend burst from the output register.
// A four-entry command queue lets the input side run ahead while a burst drains.
// Reset: synchronous active-low; window 1, threshold 16 (clamped), all counters 0.
// ----------------------------------------------------------------------------
// sliding_window_sender_congestion_ctl
// Go-back-n sender control with slow start and congestion avoidance.
// ----------------------------------------------------------------------------
module sliding_window_sender_congestion_ctl #(
    parameter int unsigned MAX_WINDOW = 64,
    parameter int unsigned SEQ_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    swsc_stream_if.sink                         i_item,
    swsc_stream_if.source                       o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    swsc_pkg::t_q_push  push;
    swsc_pkg::t_q_head  head;
    swsc_pkg::t_cfg_wr  cfg_wr;
    logic               q_full;
    logic               pop;

    // register block
    swsc_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg_wr (cfg_wr)
    );

    // accept and decode
    swsc_front u_front (
        .i_item (i_item),
        .i_full (q_full),
        .o_push (push)
    );

    // command queue
    swsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // window state and result generation
    swsc_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .i_cfg_wr (cfg_wr),
        .o_result (o_result)
    );

endmodule
